[rtl/queue_with_front_insert_and_search_assert.svh]
// Assertion macros shared by the queue checker
`ifndef QUEUE_WITH_FRONT_INSERT_AND_SEARCH_ASSERT_SVH
`define QUEUE_WITH_FRONT_INSERT_AND_SEARCH_ASSERT_SVH

// clocked check, off while reset is asserted
`define QWFIS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define QWFIS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/qwfis_pkg.sv]
// Package for the queue with front insert and search: widths, defaults, operation codes
package qwfis_pkg;

	localparam int DEPTH_DEF        = 16;
	localparam int NUMBER_WIDTH_DEF = 16;
	localparam int NUM_PORT_W       = 16;
	localparam int CNT_PORT_W       = 5;

	typedef enum logic [1:0] {
		OP_PUSH       = 2'd0,
		OP_PUSH_FRONT = 2'd1,
		OP_POP        = 2'd2,
		OP_SEARCH     = 2'd3
	} op_t;

endpackage

[rtl/queue_with_front_insert_and_search.sv]
// Ring buffer queue of vertex numbers with push, push front, pop and search
// Usage:
//   Input channel (in_valid/in_stall) carries one item: operation and vertex_number.
//   Output channel (out_valid/out_stall) returns exactly one result item per input item:
//   popped number and flag, found, rejected, queue_empty and entry_count after the step.
//   An item is taken on a clock edge with valid high and stall low.
// Result timing and throughput:
//   Push, push front, and any operation on an empty queue: result registered at the
//   accepting edge, one item per cycle while the output is not stalled.
//   Pop: the result follows one synchronous read of the entry memory.
//   Search: one memory read per held entry, walked by a single comparator; it stops
//   at the first match or after the last held entry.
//   While a pop or search is in flight the input is stalled.
// Reset (arst_n low): queue empty, head at zero, no result pending. Entry memory
//   is not cleared; only written entries are ever used in a result.
// Output stall: the result register holds; no new item is taken until it drains
//   or is taken in the same cycle.
module queue_with_front_insert_and_search #(
	parameter int DEPTH        = qwfis_pkg::DEPTH_DEF,
	parameter int NUMBER_WIDTH = qwfis_pkg::NUMBER_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       operation,
	input  logic [qwfis_pkg::NUM_PORT_W-1:0] vertex_number,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [qwfis_pkg::NUM_PORT_W-1:0] popped_number,
	output logic                             popped_valid,
	output logic                             found,
	output logic                             rejected,
	output logic                             queue_empty,
	output logic [qwfis_pkg::CNT_PORT_W-1:0] entry_count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int NW = NUMBER_WIDTH;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_SRCH
	} state_t;

	function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [CW-1:0] off);
		logic [AW:0] s;
		s = {1'b0, base} + (AW+1)'(off);
		if (s >= (AW+1)'(DEPTH))
			return AW'(s - (AW+1)'(DEPTH));
		else
			return AW'(s);
	endfunction

	logic [NW-1:0] mem [DEPTH];
	logic [NW-1:0] rd_data_s1;

	state_t          state_q, st_nxt;
	logic [AW-1:0]   head_q, head_nxt;
	logic [CW-1:0]   count_q, cnt_nxt;
	logic [CW-1:0]   sidx_q, sidx_nxt;
	logic [NW-1:0]   key_q;

	logic            out_valid_q;
	logic [qwfis_pkg::NUM_PORT_W-1:0] popped_q;
	logic            pvalid_q, found_q, rej_q, empty_q;
	logic [qwfis_pkg::CNT_PORT_W-1:0] count_out_q;

	logic            in_acc, out_free, full, empty;
	logic [NW-1:0]   num;
	logic [31:0]     vn_ext, rd_ext, cnt_ext;
	logic [AW-1:0]   head_m1, head_p1;
	logic            mem_we;
	logic [AW-1:0]   mem_wa, mem_ra;
	logic            match, done;

	logic            res_load, res_pvalid, res_found, res_rej;
	logic [qwfis_pkg::NUM_PORT_W-1:0] res_popped;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign in_acc   = in_valid && !in_stall;

	assign vn_ext  = 32'(vertex_number);
	assign num     = vn_ext[NW-1:0];
	assign rd_ext  = 32'(rd_data_s1);
	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign head_m1 = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
	assign head_p1 = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
	assign match   = (rd_data_s1 == key_q);
	assign done    = match || (sidx_q == count_q);

	always_comb begin
		st_nxt     = state_q;
		head_nxt   = head_q;
		cnt_nxt    = count_q;
		sidx_nxt   = sidx_q;
		mem_we     = 1'b0;
		mem_wa     = slot(head_q, count_q);
		mem_ra     = head_q;
		res_load   = 1'b0;
		res_popped = '0;
		res_pvalid = 1'b0;
		res_found  = 1'b0;
		res_rej    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (qwfis_pkg::op_t'(operation))
						qwfis_pkg::OP_PUSH: begin
							res_load = 1'b1;
							if (full) begin
								res_rej = 1'b1;
							end else begin
								mem_we  = 1'b1;
								cnt_nxt = count_q + CW'(1);
							end
						end
						qwfis_pkg::OP_PUSH_FRONT: begin
							res_load = 1'b1;
							if (empty || full) begin
								res_rej = 1'b1;
							end else begin
								mem_we   = 1'b1;
								mem_wa   = head_m1;
								head_nxt = head_m1;
								cnt_nxt  = count_q + CW'(1);
							end
						end
						qwfis_pkg::OP_POP: begin
							if (empty)
								res_load = 1'b1;
							else
								st_nxt = ST_POP;
						end
						qwfis_pkg::OP_SEARCH: begin
							if (empty) begin
								res_load = 1'b1;
							end else begin
								sidx_nxt = CW'(1);
								st_nxt   = ST_SRCH;
							end
						end
						default: res_load = 1'b1;
					endcase
				end
			end
			ST_POP: begin
				if (out_free) begin
					res_load   = 1'b1;
					res_popped = rd_ext[qwfis_pkg::NUM_PORT_W-1:0];
					res_pvalid = 1'b1;
					head_nxt   = head_p1;
					cnt_nxt    = count_q - CW'(1);
					st_nxt     = ST_IDLE;
				end
			end
			ST_SRCH: begin
				if (done) begin
					// re-read the checked entry so the compare holds across an output stall
					mem_ra = slot(head_q, sidx_q - CW'(1));
					if (out_free) begin
						res_load  = 1'b1;
						res_found = match;
						st_nxt    = ST_IDLE;
					end
				end else begin
					mem_ra   = slot(head_q, sidx_q);
					sidx_nxt = sidx_q + CW'(1);
				end
			end
			default: st_nxt = ST_IDLE;
		endcase
	end

	assign cnt_ext = 32'(cnt_nxt);

	// writes happen only at accept; a read of an entry being written is never used
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= num;
		rd_data_s1 <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			sidx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= st_nxt;
			head_q  <= head_nxt;
			count_q <= cnt_nxt;
			sidx_q  <= sidx_nxt;
			if (res_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			key_q <= num;
		if (res_load) begin
			popped_q    <= res_popped;
			pvalid_q    <= res_pvalid;
			found_q     <= res_found;
			rej_q       <= res_rej;
			empty_q     <= (cnt_nxt == '0);
			count_out_q <= cnt_ext[qwfis_pkg::CNT_PORT_W-1:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign popped_number = popped_q;
	assign popped_valid  = pvalid_q;
	assign found         = found_q;
	assign rejected      = rej_q;
	assign queue_empty   = empty_q;
	assign entry_count   = count_out_q;

endmodule

[rtl/qwfis_chk.sv]
// Port-level checker for the queue with front insert and search, bound to the top level
`include "queue_with_front_insert_and_search_assert.svh"

module qwfis_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic [1:0]                       operation,
	input logic [qwfis_pkg::NUM_PORT_W-1:0] vertex_number,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [qwfis_pkg::NUM_PORT_W-1:0] popped_number,
	input logic                             popped_valid,
	input logic                             found,
	input logic                             rejected,
	input logic                             queue_empty,
	input logic [qwfis_pkg::CNT_PORT_W-1:0] entry_count
);

	logic [qwfis_pkg::NUM_PORT_W+qwfis_pkg::CNT_PORT_W+3:0] result_bits;
	logic [qwfis_pkg::NUM_PORT_W+1:0]                       item_bits;

	assign result_bits = {popped_number, popped_valid, found, rejected, queue_empty, entry_count};
	assign item_bits   = {operation, vertex_number};

	`QWFIS_ASSERT_ALWAYS(a_no_result_in_reset, !arst_n |-> !out_valid, "result valid in reset")
	`QWFIS_ASSERT(a_hold_on_stall, out_valid && out_stall |=> out_valid && $stable(result_bits), "result changed under stall")
	`QWFIS_ASSERT(a_in_hold, in_valid && in_stall |=> in_valid && $stable(item_bits), "item changed under stall")
	`QWFIS_ASSERT(a_pop_exclusive, out_valid && popped_valid |-> !found && !rejected, "pop flags")
	`QWFIS_ASSERT(a_found_nonempty, out_valid && found |-> !queue_empty && !rejected, "found flags")

endmodule

bind queue_with_front_insert_and_search qwfis_chk u_qwfis_chk (.*);

[tb/sv/queue_with_front_insert_and_search_tb.sv]
// Self-checking testbench for the vertex queue with push, push front, pop and search
`timescale 1ns / 100ps

module queue_with_front_insert_and_search_tb;

	localparam int DEPTH       = qwfis_pkg::DEPTH_DEF;
	localparam int NUM_W       = qwfis_pkg::NUM_PORT_W;
	localparam int CNT_W       = qwfis_pkg::CNT_PORT_W;
	localparam int RANDOM_OPS  = 1050;
	localparam int HOLD_CYCLES = 120;
	localparam int IDLE_LIMIT  = 1000;
	localparam int SETTLE      = 40;

	typedef enum {KIND_VERTEX_OP, KIND_WAIT_EMPTY, KIND_HOLD_OUTPUT} step_kind_t;

	typedef struct {
		step_kind_t       kind;
		qwfis_pkg::op_t   op;
		logic [NUM_W-1:0] number;
		int               idle_before;
	} pending_step_t;

	typedef struct packed {
		logic [NUM_W-1:0] popped_number;
		logic             popped_valid;
		logic             found;
		logic             rejected;
		logic             queue_empty;
		logic [CNT_W-1:0] entry_count;
	} outcome_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [1:0]       operation = qwfis_pkg::OP_PUSH;
	logic [NUM_W-1:0] vertex_number = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [NUM_W-1:0] popped_number;
	logic             popped_valid;
	logic             found;
	logic             rejected;
	logic             queue_empty;
	logic [CNT_W-1:0] entry_count;

	pending_step_t    pending_steps[$];
	outcome_t         expected_outcomes[$];
	logic [NUM_W-1:0] shadow_entries[$];
	logic [NUM_W-1:0] ring [DEPTH];
	int               ring_head = 0;
	int               ring_count = 0;
	int               fail_count = 0;
	int               hold_requests = 0;
	int               holds_served = 0;
	int               hold_left = 0;
	int               stall_left = 0;
	int               results_taken = 0;
	bit               receiver_idles = 1'b1;
	bit               sender_idles = 1'b1;
	int               idle_cycles = 0;

	queue_with_front_insert_and_search dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.vertex_number(vertex_number),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.popped_number(popped_number),
		.popped_valid(popped_valid),
		.found(found),
		.rejected(rejected),
		.queue_empty(queue_empty),
		.entry_count(entry_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic outcome_t predict_outcome(qwfis_pkg::op_t op, logic [NUM_W-1:0] number);
		outcome_t r;
		r = '0;
		case (op)
			qwfis_pkg::OP_PUSH: begin
				if (ring_count >= DEPTH) begin
					r.rejected = 1'b1;
				end else begin
					ring[(ring_head + ring_count) % DEPTH] = number;
					ring_count++;
				end
			end
			qwfis_pkg::OP_PUSH_FRONT: begin
				if (ring_count == 0 || ring_count >= DEPTH) begin
					r.rejected = 1'b1;
				end else begin
					ring_head = (ring_head + DEPTH - 1) % DEPTH;
					ring[ring_head] = number;
					ring_count++;
				end
			end
			qwfis_pkg::OP_POP: begin
				if (ring_count != 0) begin
					r.popped_number = ring[ring_head];
					r.popped_valid = 1'b1;
					ring_head = (ring_head + 1) % DEPTH;
					ring_count--;
				end
			end
			default: begin
				for (int i = 0; i < ring_count; i++)
					if (ring[(ring_head + i) % DEPTH] == number)
						r.found = 1'b1;
			end
		endcase
		r.queue_empty = (ring_count == 0);
		r.entry_count = CNT_W'(ring_count);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		fail_count++;
		if (fail_count <= 100)
			$display("MISMATCH at %0t: %s got %0h expected %0h", $time, what, got, want);
	endtask

	// shadow of the queue contents at generation time, used to aim searches
	task automatic add_op(qwfis_pkg::op_t op, logic [NUM_W-1:0] number);
		pending_step_t s;
		s.kind = KIND_VERTEX_OP;
		s.op = op;
		s.number = number;
		s.idle_before = sender_idles ? $urandom_range(0, 8) : 0;
		pending_steps.push_back(s);
		case (op)
			qwfis_pkg::OP_PUSH:
				if (shadow_entries.size() < DEPTH) shadow_entries.push_back(number);
			qwfis_pkg::OP_PUSH_FRONT:
				if (shadow_entries.size() != 0 && shadow_entries.size() < DEPTH)
					shadow_entries.push_front(number);
			qwfis_pkg::OP_POP:
				if (shadow_entries.size() != 0) void'(shadow_entries.pop_front());
			default: ;
		endcase
	endtask

	task automatic add_marker(step_kind_t kind);
		pending_step_t s;
		s.kind = kind;
		s.op = qwfis_pkg::OP_SEARCH;
		s.number = '0;
		s.idle_before = 0;
		pending_steps.push_back(s);
	endtask

	function automatic logic [NUM_W-1:0] pick_number(bit from_held);
		int sel;
		sel = $urandom_range(0, 3);
		if (from_held && shadow_entries.size() != 0 && $urandom_range(0, 1) == 1)
			return shadow_entries[$urandom_range(0, shadow_entries.size() - 1)];
		case (sel)
			0: return NUM_W'($urandom_range(0, 7));
			1: return $urandom_range(0, 1) ? '1 : '0;
			default: return NUM_W'($urandom_range(0, 65535));
		endcase
	endfunction

	always @(posedge clk) begin : driver
		logic offering;
		pending_step_t s;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			offering = in_valid;
			if (in_valid && !in_stall) begin
				expected_outcomes.push_back(
					predict_outcome(qwfis_pkg::op_t'(operation), vertex_number));
				offering = 1'b0;
			end
			if (!offering && pending_steps.size() != 0) begin
				s = pending_steps[0];
				case (s.kind)
					KIND_WAIT_EMPTY:
						if (expected_outcomes.size() == 0)
							void'(pending_steps.pop_front());
					KIND_HOLD_OUTPUT: begin
						hold_requests <= hold_requests + 1;
						void'(pending_steps.pop_front());
					end
					default: begin
						if (s.idle_before > 0) begin
							pending_steps[0].idle_before = s.idle_before - 1;
						end else begin
							operation <= s.op;
							vertex_number <= s.number;
							offering = 1'b1;
							void'(pending_steps.pop_front());
						end
					end
				endcase
			end
			in_valid <= offering;
		end
	end

	always @(posedge clk) begin : monitor
		outcome_t want;
		logic stall_next;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_outcomes.size() == 0) begin
					report_mismatch("result with no item pending", 32'(entry_count), 32'(0));
				end else begin
					want = expected_outcomes.pop_front();
					if (popped_number !== want.popped_number)
						report_mismatch("popped_number", 32'(popped_number),
							32'(want.popped_number));
					if (popped_valid !== want.popped_valid)
						report_mismatch("popped_valid", 32'(popped_valid),
							32'(want.popped_valid));
					if (found !== want.found)
						report_mismatch("found", 32'(found), 32'(want.found));
					if (rejected !== want.rejected)
						report_mismatch("rejected", 32'(rejected), 32'(want.rejected));
					if (queue_empty !== want.queue_empty)
						report_mismatch("queue_empty", 32'(queue_empty), 32'(want.queue_empty));
					if (entry_count !== want.entry_count)
						report_mismatch("entry_count", 32'(entry_count), 32'(want.entry_count));
				end
				results_taken++;
				if (results_taken % 45 == 0)
					receiver_idles = 1'($urandom_range(0, 1));
				stall_left = receiver_idles ? $urandom_range(0, 8) : 0;
			end
			if (holds_served != hold_requests) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				stall_next = 1'b1;
			end else begin
				stall_next = 1'b0;
			end
			out_stall <= stall_next;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin : sequencer
		int roll;
		int phase;
		int t_push;
		int t_front;
		int t_pop;
		qwfis_pkg::op_t op;

		// empty queue corners, then both ends of the number range
		add_op(qwfis_pkg::OP_POP, 16'h0000);
		add_op(qwfis_pkg::OP_SEARCH, 16'h0000);
		add_op(qwfis_pkg::OP_PUSH_FRONT, 16'h1234);
		add_op(qwfis_pkg::OP_PUSH, 16'h0000);
		add_op(qwfis_pkg::OP_PUSH, 16'hffff);
		add_op(qwfis_pkg::OP_PUSH_FRONT, 16'haaaa);
		add_op(qwfis_pkg::OP_SEARCH, 16'hffff);
		add_op(qwfis_pkg::OP_SEARCH, 16'h5555);
		add_op(qwfis_pkg::OP_POP, 16'h0000);
		// fill up, then full queue corners and a search of the last entry
		while (shadow_entries.size() < DEPTH)
			add_op(qwfis_pkg::OP_PUSH, NUM_W'($urandom_range(0, 65535)));
		add_op(qwfis_pkg::OP_PUSH, 16'h7777);
		add_op(qwfis_pkg::OP_PUSH_FRONT, 16'h8888);
		add_op(qwfis_pkg::OP_SEARCH, shadow_entries[DEPTH - 1]);
		add_op(qwfis_pkg::OP_POP, 16'h0000);
		add_marker(KIND_WAIT_EMPTY);

		phase = 0;
		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (n % 150 == 0)
				phase = $urandom_range(0, 2);
			if (n % 60 == 0)
				sender_idles = 1'($urandom_range(0, 1));
			if (n == 300 || n == 750)
				add_marker(KIND_HOLD_OUTPUT);
			if (n % 200 == 199)
				add_marker(KIND_WAIT_EMPTY);
			case (phase)
				0: begin t_push = 55; t_front = 75; t_pop = 85; end
				1: begin t_push = 15; t_front = 25; t_pop = 80; end
				default: begin t_push = 30; t_front = 45; t_pop = 75; end
			endcase
			roll = $urandom_range(0, 99);
			if (roll < t_push)
				op = qwfis_pkg::OP_PUSH;
			else if (roll < t_front)
				op = qwfis_pkg::OP_PUSH_FRONT;
			else if (roll < t_pop)
				op = qwfis_pkg::OP_POP;
			else
				op = qwfis_pkg::OP_SEARCH;
			add_op(op, pick_number(op == qwfis_pkg::OP_SEARCH || op == qwfis_pkg::OP_PUSH));
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_steps.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_outcomes.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0 && expected_outcomes.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[queue_with_front_insert_and_search.f]
+incdir+rtl
rtl/qwfis_pkg.sv
rtl/queue_with_front_insert_and_search.sv
rtl/qwfis_chk.sv
tb/sv/queue_with_front_insert_and_search_tb.sv
